// ----- rtl/core/adf_pkg.sv -----
// Package: shared constants, register map and field widths of the audio DMA interface.
`timescale 1ns / 1ps

package adf_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned LEN_W   = 18;
  localparam int unsigned FREQ_W  = 26;
  localparam int unsigned RATE_W  = 14;
  localparam int unsigned STEP_W  = 42;
  localparam int unsigned PER_W   = 56;
  localparam int unsigned LOW_W   = 13;

  // Transaction commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Register map (bus offset bits 4..2)
  localparam logic [IDX_W-1:0] REG_ADDR    = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CTRL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STATUS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DACRATE = 3'd4;
  localparam logic [IDX_W-1:0] REG_BITRATE = 3'd5;

  // Write masks and address stepping
  localparam logic [ADDR_W-1:0] ADDR_MASK  = 24'hfffff8;
  localparam logic [LEN_W-1:0]  LEN_MASK   = 18'h3fff8;
  localparam logic [ADDR_W-1:0] CARRY_STEP = 24'h002000;
  localparam logic [LOW_W-1:0]  WORD_STEP  = 13'd4;
  localparam logic [LEN_W-1:0]  LEN_STEP   = 18'd4;

  // Status word bits that always read as one
  localparam logic [DATA_W-1:0] STATUS_BASE = 32'h0110_0000;

  // Clock figures
  localparam logic [FREQ_W-1:0] FREQ_MIN   = 26'd1000000;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 26'd62499999;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 26'd48681812;
  localparam logic [63:0]       RCP_HZ     = 64'd62500000;
  localparam logic [63:0]       AUDIO_HZ   = 64'd44100;

  // Derived reset values and the period scale for DAC rate writes
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'(FREQ_RESET) * AUDIO_HZ);
  localparam logic [PER_W-1:0]  PER_RESET  = PER_W'(64'(FREQ_RESET) * RCP_HZ);
  localparam logic [PER_W-1:0]  RATE_K     = PER_W'(RCP_HZ * AUDIO_HZ);

endpackage

// ----- rtl/core/adf_if.sv -----
// Interfaces: request and result channels of the audio DMA interface.
`timescale 1ns / 1ps

interface adf_in_if;
  logic                               valid;
  logic                               ready;
  logic [adf_pkg::CMD_W-1:0]          command;
  logic [adf_pkg::IDX_W-1:0]          reg_index;
  logic [adf_pkg::DATA_W-1:0]         write_data;

  modport source (output valid, command, reg_index, write_data, input ready);
  modport sink   (input valid, command, reg_index, write_data, output ready);
endinterface

interface adf_out_if;
  logic                               valid;
  logic                               ready;
  logic [adf_pkg::DATA_W-1:0]         read_data;
  logic                               interrupt_level;
  logic                               fetch_valid;
  logic [adf_pkg::ADDR_W-1:0]         fetch_address;
  logic                               period_boundary;

  modport source (output valid, read_data, interrupt_level, fetch_valid, fetch_address,
                  period_boundary, input ready);
  modport sink   (input valid, read_data, interrupt_level, fetch_valid, fetch_address,
                  period_boundary, output ready);
endinterface

// ----- rtl/core/audio_dma_fifo_interface.sv -----
// Top level: audio DMA interface with two-entry DMA queue and sample phase accumulator.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------------------
//  in_ch    | in        | valid / ready    | command, reg_index, write_data
//  out_ch   | out       | valid / ready    | read_data, interrupt_level, fetch_valid,
//           |           |                  | fetch_address, period_boundary
//  cfg_     | in        | cfg_we           | cfg_wdata (video frequency, Hz)
//
// One transaction per clock when not busy and no result is stalled; each result lands
// in the output register the cycle after. A period boundary that leaves the queue idle,
// or a length pending with DMA off, after the sample period has been rewritten starts
// the remainder unit: in_ch.ready is low while it runs, one remainder bit per cycle.
// Reset (rst_n low, synchronous) sets all control state to its reset values. A stalled
// result holds in the output register; a new transaction is still taken in the cycle
// the old result leaves. The bit rate register has no visible effect.
`timescale 1ns / 1ps

module audio_dma_fifo_interface (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [adf_pkg::FREQ_W-1:0]  cfg_wdata,
  adf_in_if.sink                      in_ch,
  adf_out_if.source                   out_ch
);

  localparam int unsigned AW  = adf_pkg::ADDR_W;
  localparam int unsigned LW  = adf_pkg::LEN_W;
  localparam int unsigned PW  = adf_pkg::PER_W;
  localparam int unsigned SW  = adf_pkg::STEP_W;
  localparam int unsigned DW  = adf_pkg::DATA_W;
  localparam int unsigned CW  = $clog2(PW);

  // Registers
  logic [SW-1:0] step_r, step_nxt;
  logic [PW-1:0] period_r, period_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          over_r, over_nxt;
  logic          rate_wr_r, rate_wr_nxt;
  logic [AW-1:0] addr_r [2];
  logic [AW-1:0] addr_nxt [2];
  logic [LW-1:0] len_r [2];
  logic [LW-1:0] len_nxt [2];
  logic [1:0]    count_r, count_nxt;
  logic          dma_r, dma_nxt;
  logic          carry_r, carry_nxt;
  logic          irq_r, irq_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [DW-1:0] rd_r, rd_nxt;
  logic          fv_r, fv_nxt;
  logic [AW-1:0] fa_r, fa_nxt;
  logic          bnd_r, bnd_nxt;

  // Handshake and command decode
  logic take, is_tick, is_read, is_write;
  assign in_ch.ready = !busy_r && (!ovalid_r || out_ch.ready);
  assign take     = in_ch.valid && in_ch.ready;
  assign is_tick  = take && (in_ch.command == adf_pkg::CMD_TICK);
  assign is_read  = take && (in_ch.command == adf_pkg::CMD_READ);
  assign is_write = take && (in_ch.command == adf_pkg::CMD_WRITE);

  // Phase accumulator: sum and sum minus period side by side
  logic [PW:0]   sum;
  logic [PW+1:0] diff;
  logic          bnd;
  assign sum  = {1'b0, acc_r} + (PW+1)'(step_r);
  assign diff = {1'b0, sum} - {2'b00, period_r};
  assign bnd  = is_tick && !diff[PW+1];

  // One elapsed period: fetch, length step and queue pop
  logic          q_any, fetch, pop, handoff, mod_cond, start_mod;
  logic [AW-1:0] a_c, addr_f;
  logic [adf_pkg::LOW_W-1:0] low;
  logic [LW-1:0] len_post, len_fin;
  logic [1:0]    count_post;
  assign q_any      = (count_r != 2'd0);
  assign fetch      = q_any && (len_r[0] != '0) && dma_r;
  assign a_c        = carry_r ? addr_r[0] + adf_pkg::CARRY_STEP : addr_r[0];
  assign low        = a_c[adf_pkg::LOW_W-1:0] + adf_pkg::WORD_STEP;
  assign addr_f     = {a_c[AW-1:adf_pkg::LOW_W], low};
  assign len_post   = fetch ? len_r[0] - adf_pkg::LEN_STEP : len_r[0];
  assign pop        = q_any && (len_post == '0);
  assign count_post = pop ? count_r - 2'd1 : count_r;
  assign handoff    = pop && (count_post != 2'd0);
  assign len_fin    = handoff ? len_r[1] : len_post;
  assign mod_cond   = (count_post == 2'd0) || (!dma_r && (len_fin != '0));
  assign start_mod  = bnd && mod_cond && over_r;

  // Remainder step: one dividend bit per cycle
  logic [PW:0] trial;
  logic        trial_ge;
  assign trial    = {rem_r, acc_r[PW-1]};
  assign trial_ge = (trial >= {1'b0, dsr_r});

  // Saturated configuration value
  logic [adf_pkg::FREQ_W-1:0] vf_sat;
  always_comb begin
    priority if (cfg_wdata < adf_pkg::FREQ_MIN) begin
      vf_sat = adf_pkg::FREQ_MIN;
    end else if (cfg_wdata > adf_pkg::FREQ_MAX) begin
      vf_sat = adf_pkg::FREQ_MAX;
    end else begin
      vf_sat = cfg_wdata;
    end
  end

  // Status and length read value
  logic [DW-1:0] rd_val;
  always_comb begin
    if (in_ch.reg_index == adf_pkg::REG_STATUS) begin
      rd_val     = adf_pkg::STATUS_BASE;
      rd_val[25] = dma_r;
      rd_val[30] = q_any;
      rd_val[31] = count_r[1];
      rd_val[0]  = count_r[1];
    end else begin
      rd_val = DW'(len_r[0]);
    end
  end

  // Next-state logic
  always_comb begin
    step_nxt    = step_r;
    period_nxt  = period_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    over_nxt    = over_r;
    rate_wr_nxt = rate_wr_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    dma_nxt     = dma_r;
    carry_nxt   = carry_r;
    irq_nxt     = irq_r;

    // remainder unit runs while the input side is held off
    if (busy_r) begin
      rem_nxt = trial_ge ? PW'(trial - {1'b0, dsr_r}) : trial[PW-1:0];
      acc_nxt = {acc_r[PW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        acc_nxt  = rem_nxt;
      end
    end

    // tick: advance phase, and on a boundary run the DMA step
    if (is_tick) begin
      acc_nxt = bnd ? diff[PW-1:0] : sum[PW-1:0];
      if (bnd) begin
        if (fetch) begin
          addr_nxt[0] = addr_f;
          carry_nxt   = (low == '0);
        end
        len_nxt[0] = len_post;
        count_nxt  = count_post;
        if (handoff) begin
          addr_nxt[0] = addr_r[1];
          len_nxt[0]  = len_r[1];
          irq_nxt     = 1'b1;
        end
      end
      if (start_mod) begin
        busy_nxt = 1'b1;
        over_nxt = 1'b0;
        rem_nxt  = '0;
        dsr_nxt  = period_r;
        cnt_nxt  = CW'(PW - 1);
      end
    end

    // register writes
    if (is_write) begin
      unique case (in_ch.reg_index)
        adf_pkg::REG_ADDR: begin
          if (!count_r[1]) begin
            addr_nxt[count_r[0]] = in_ch.write_data[AW-1:0] & adf_pkg::ADDR_MASK;
          end
        end
        adf_pkg::REG_LEN: begin
          if (!count_r[1]) begin
            len_nxt[count_r[0]] = in_ch.write_data[LW-1:0] & adf_pkg::LEN_MASK;
            if (!q_any) begin
              irq_nxt = 1'b1;
            end
            count_nxt = count_r + 2'd1;
          end
        end
        adf_pkg::REG_CTRL: begin
          dma_nxt = in_ch.write_data[0];
        end
        adf_pkg::REG_STATUS: begin
          irq_nxt = 1'b0;
        end
        adf_pkg::REG_DACRATE: begin
          rate_wr_nxt = 1'b1;
          over_nxt    = 1'b1;
          period_nxt  = PW'(adf_pkg::RATE_K *
                            PW'({1'b0, in_ch.write_data[adf_pkg::RATE_W-1:0]} + 15'd1));
        end
        adf_pkg::REG_BITRATE: begin
          // bit rate only drives the DAC, which is not modelled here
          dma_nxt = dma_r;
        end
        default: begin
          dma_nxt = dma_r;
        end
      endcase
    end

    // configuration: phase step always, period while no DAC rate is set
    if (cfg_we) begin
      step_nxt = SW'(64'(vf_sat) * adf_pkg::AUDIO_HZ);
      if (!rate_wr_r) begin
        period_nxt = PW'(64'(vf_sat) * adf_pkg::RCP_HZ);
        over_nxt   = 1'b1;
      end
    end
  end

  // Result register
  always_comb begin
    ovalid_nxt = ovalid_r;
    rd_nxt     = rd_r;
    fv_nxt     = fv_r;
    fa_nxt     = fa_r;
    bnd_nxt    = bnd_r;
    if (take) begin
      ovalid_nxt = 1'b1;
      rd_nxt     = is_read ? rd_val : '0;
      fv_nxt     = bnd && fetch;
      fa_nxt     = (bnd && fetch) ? a_c : '0;
      bnd_nxt    = bnd;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= adf_pkg::STEP_RESET;
      period_r  <= adf_pkg::PER_RESET;
      acc_r     <= '0;
      cnt_r     <= '0;
      busy_r    <= 1'b0;
      over_r    <= 1'b0;
      rate_wr_r <= 1'b0;
      addr_r[0] <= '0;
      addr_r[1] <= '0;
      len_r[0]  <= '0;
      len_r[1]  <= '0;
      count_r   <= '0;
      dma_r     <= 1'b0;
      carry_r   <= 1'b0;
      irq_r     <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      period_r  <= period_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      busy_r    <= busy_nxt;
      over_r    <= over_nxt;
      rate_wr_r <= rate_wr_nxt;
      addr_r    <= addr_nxt;
      len_r     <= len_nxt;
      count_r   <= count_nxt;
      dma_r     <= dma_nxt;
      carry_r   <= carry_nxt;
      irq_r     <= irq_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    rd_r  <= rd_nxt;
    fv_r  <= fv_nxt;
    fa_r  <= fa_nxt;
    bnd_r <= bnd_nxt;
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.read_data       = rd_r;
  assign out_ch.interrupt_level = (irq_r & ovalid_r) | (irq_r & !ovalid_r);
  assign out_ch.fetch_valid     = fv_r;
  assign out_ch.fetch_address   = fa_r;
  assign out_ch.period_boundary = bnd_r;

  // Checks
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready)
    else $error("transaction taken while remainder unit busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  // fetched words sit on 4-byte boundaries
  a_fetch_on_bnd: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_ch.fetch_valid |-> out_ch.period_boundary &&
    (out_ch.fetch_address[1:0] == 2'd0))
    else $error("fetch without period boundary or misaligned");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(is_tick) && $past(bnd) && !over_r)
    else $error("remainder unit started outside a boundary");

endmodule
